>>> rtl/bcd_pkg.sv
// ============================================================================
// bcd_pkg: shared types and constants for the bounded circular deque
// Holds the item layouts of both channels, the operation codes, the
// configuration register map and the default sizes of the ring store.
// ============================================================================
package bcd_pkg;

  // Default sizes of the ring store.
  localparam int DEPTH_DEFAULT      = 64;
  localparam int DATA_WIDTH_DEFAULT = 32;

  // Fixed field widths of the channels.
  localparam int OP_W    = 3;
  localparam int VALUE_W = 32;
  localparam int CAP_W   = 7;
  localparam int OCC_W   = 7;

  // Configuration port.
  localparam int              CFG_DATA_W  = 32;
  localparam int              CFG_ADDR_W  = 2;
  localparam logic [CAP_W-1:0] CAP_RESET  = 7'd64;

  // Register word indexes.
  localparam logic [CFG_ADDR_W-1:0] REG_CAPACITY = '0;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_INS_REAR  = 3'd1;
  localparam logic [OP_W-1:0] OP_DEL_FRONT = 3'd2;
  localparam logic [OP_W-1:0] OP_DEL_REAR  = 3'd3;
  localparam logic [OP_W-1:0] OP_PEEK      = 3'd4;

  // One input item.
  typedef struct packed {
    logic        [OP_W-1:0]    op;
    logic signed [VALUE_W-1:0] value;
  } bcd_in_t;

  // One result item.
  typedef struct packed {
    logic                      ok;
    logic signed [VALUE_W-1:0] front_value;
    logic signed [VALUE_W-1:0] rear_value;
    logic                      is_empty;
    logic                      is_full;
    logic        [OCC_W-1:0]   occupancy;
  } bcd_out_t;

endpackage

>>> rtl/bounded_circular_deque_unit.sv
// ============================================================================
// bounded_circular_deque_unit: double-ended queue in a ring memory
// Inserts and deletes at either end of a ring of DEPTH words, limited by a
// programmable capacity, and reports the deque after every operation.
// ============================================================================
// Usage:
// Each input item (in_valid / in_stall / in_data) carries an operation code
// and a data word. Every item produces exactly one result item on the
// out_valid / out_stall / out_data channel: a success flag, the front and
// rear words after the operation (all ones when empty), the empty and full
// flags and the occupancy.
// At the accept edge the pointers are updated and an insert writes the ring
// memory; then, in the read state once the result register is free, the
// memory is read at the front and rear addresses and the result register is
// loaded, raising out_valid. in_stall is high while that read is outstanding,
// so a new item is not accepted before the last one has been read.
// The result sits in an output register; the next item is accepted while it
// waits. While the receiver stalls, that next item stays in its read cycle
// with in_stall high until the result register is taken, so the block holds
// at most one finished result and one item in flight.
// The capacity register (APB, byte address 0) resets to 64. The user must
// write it only while the block is idle; the block does not enforce this.
// Synchronous reset empties the deque; the memory contents are not cleared.
// ============================================================================
module bounded_circular_deque_unit
  import bcd_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEFAULT,
  parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  bcd_in_t               in_data,
  // Result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output bcd_out_t              out_data,
  // Configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;
  localparam int EW = (CW > CAP_W) ? CW : CAP_W;
  localparam logic [DATA_WIDTH-1:0] EMPTY_WORD = '1;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_t;

  state_t                state_r;
  logic [AW-1:0]         head_r, head_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [CAP_W-1:0]      capacity_r;
  logic                  ok_r, ok_nxt;
  logic                  out_valid_r;
  logic                  out_ok_r, out_empty_r, out_full_r;
  logic [CW-1:0]         out_count_r;
  logic [DATA_WIDTH-1:0] rd_front_r, rd_rear_r;

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  logic                  in_acc, slot_free, rd_en;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr, rear_addr;
  logic [DATA_WIDTH-1:0] wr_word;
  logic [EW-1:0]         cap_eff;
  logic                  has_room;
  logic [SW-1:0]         ins_sum, rear_sum;
  logic [CFG_ADDR_W-1:0] cfg_word;
  logic                  cfg_wr;

  // Configuration port: single register, always ready.
  assign pready   = 1'b1;
  assign cfg_word = paddr >> 2;
  assign cfg_wr   = psel && penable && pwrite && pready && (cfg_word == REG_CAPACITY);
  assign prdata   = (cfg_word == REG_CAPACITY) ? CFG_DATA_W'(capacity_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAP_RESET;
    end else if (cfg_wr) begin
      capacity_r <= pwdata[CAP_W-1:0];
    end
  end

  // Handshakes. A new item waits while the memory read is outstanding.
  assign in_stall  = (state_r == ST_READ);
  assign in_acc    = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;
  assign rd_en     = (state_r == ST_READ) && slot_free;

  // Capacity saturates at the ring depth.
  assign cap_eff  = (EW'(capacity_r) > EW'(DEPTH)) ? EW'(DEPTH) : EW'(capacity_r);
  assign has_room = EW'(count_r) < cap_eff;

  // Slot behind the rear entry, wrapped around the ring.
  always_comb begin
    ins_sum = SW'(head_r) + SW'(count_r);
    if (ins_sum >= SW'(DEPTH)) begin
      ins_sum = ins_sum - SW'(DEPTH);
    end
  end

  assign wr_word = DATA_WIDTH'($unsigned(in_data.value));

  // Pointer update and memory write for the accepted item.
  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    ok_nxt    = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = ins_sum[AW-1:0];
    case (in_data.op)
      OP_INS_FRONT: begin
        if (has_room) begin
          head_nxt  = (head_r == '0) ? AW'(DEPTH - 1) : head_r - 1'b1;
          wr_addr   = head_nxt;
          wr_en     = 1'b1;
          count_nxt = count_r + 1'b1;
          ok_nxt    = 1'b1;
        end
      end
      OP_INS_REAR: begin
        if (has_room) begin
          wr_en     = 1'b1;
          count_nxt = count_r + 1'b1;
          ok_nxt    = 1'b1;
        end
      end
      OP_DEL_FRONT: begin
        if (count_r != '0) begin
          head_nxt  = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + 1'b1;
          count_nxt = count_r - 1'b1;
          ok_nxt    = 1'b1;
        end
      end
      OP_DEL_REAR: begin
        if (count_r != '0) begin
          count_nxt = count_r - 1'b1;
          ok_nxt    = 1'b1;
        end
      end
      OP_PEEK: begin
        ok_nxt = 1'b1;
      end
      default: begin
        ok_nxt = 1'b0;
      end
    endcase
  end

  // Address of the rear entry; meaningless when the deque is empty.
  always_comb begin
    rear_sum = SW'(head_r) + SW'(count_r) - 1'b1;
    if (rear_sum >= SW'(DEPTH)) begin
      rear_sum = rear_sum - SW'(DEPTH);
    end
  end
  assign rear_addr = rear_sum[AW-1:0];

  // Ring memory: one write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (in_acc && wr_en) begin
      mem[wr_addr] <= wr_word;
    end
    if (rd_en) begin
      rd_front_r <= mem[head_r];
      rd_rear_r  <= mem[rear_addr];
    end
  end

  // Sequencer, pointer state and registered result flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      ok_r        <= 1'b0;
      out_valid_r <= 1'b0;
      out_ok_r    <= 1'b0;
      out_empty_r <= 1'b1;
      out_full_r  <= 1'b0;
      out_count_r <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            head_r  <= head_nxt;
            count_r <= count_nxt;
            ok_r    <= ok_nxt;
            state_r <= ST_READ;
          end
        end
        ST_READ: begin
          if (rd_en) begin
            out_ok_r    <= ok_r;
            out_empty_r <= (count_r == '0);
            out_full_r  <= !has_room;
            out_count_r <= count_r;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase

      // The result register empties when taken and refills from a read.
      if (rd_en) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result item; an empty deque reports all ones at both ends.
  assign out_valid            = out_valid_r;
  assign out_data.ok          = out_ok_r;
  assign out_data.front_value = VALUE_W'(out_empty_r ? EMPTY_WORD : rd_front_r);
  assign out_data.rear_value  = VALUE_W'(out_empty_r ? EMPTY_WORD : rd_rear_r);
  assign out_data.is_empty    = out_empty_r;
  assign out_data.is_full     = out_full_r;
  assign out_data.occupancy   = OCC_W'(out_count_r);

endmodule

>>> tb/bounded_circular_deque_checker.sv
`timescale 1ns / 100ps
// ============================================================================
// bounded_circular_deque_checker: result predictor and scoreboard
// Watches the input, result and configuration channels of the deque, keeps
// its own copy of the ring, head, count and capacity, works out the result of
// every accepted item and compares each accepted result field by field.
// ============================================================================
module bounded_circular_deque_checker
  import bcd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  bcd_in_t               in_data,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  bcd_out_t              out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  input  logic [CFG_DATA_W-1:0] prdata,
  input  logic                  pready,
  output int                    fail_count,
  output int                    pending_count,
  output int                    checked_count,
  output int                    refused_count,
  output int                    full_count
);

  // Room for predictions still owed; the block never holds more than two.
  localparam int OWED_DEPTH = 16;

  // Shadow copy of the deque.
  logic [VALUE_W-1:0] ring_words [DEPTH_DEFAULT];
  int                 head_pos;
  int                 occ;
  logic [CAP_W-1:0]   capacity;

  // Results still owed by the block, oldest at the read position.
  bcd_out_t           owed_results [OWED_DEPTH];
  int                 owed_rd;
  int                 owed_wr;

  int errors;
  int checked;
  int refused;
  int fulls;

  // Applies one operation to the shadow deque and returns the result it yields.
  function automatic bcd_out_t deque_apply(bcd_in_t item);
    bcd_out_t res;
    int       limit;
    limit = (int'(capacity) > DEPTH_DEFAULT) ? DEPTH_DEFAULT : int'(capacity);
    res = '0;
    res.front_value = '1;
    res.rear_value  = '1;
    case (item.op)
      OP_INS_FRONT: begin
        if (occ < limit) begin
          head_pos = (head_pos + DEPTH_DEFAULT - 1) % DEPTH_DEFAULT;
          ring_words[head_pos] = item.value;
          occ++;
          res.ok = 1'b1;
        end
      end
      OP_INS_REAR: begin
        if (occ < limit) begin
          ring_words[(head_pos + occ) % DEPTH_DEFAULT] = item.value;
          occ++;
          res.ok = 1'b1;
        end
      end
      OP_DEL_FRONT: begin
        if (occ != 0) begin
          head_pos = (head_pos + 1) % DEPTH_DEFAULT;
          occ--;
          res.ok = 1'b1;
        end
      end
      OP_DEL_REAR: begin
        if (occ != 0) begin
          occ--;
          res.ok = 1'b1;
        end
      end
      OP_PEEK: begin
        res.ok = 1'b1;
      end
      default: begin
        // Unused codes change nothing and report as a failed peek.
      end
    endcase
    if (occ != 0) begin
      res.front_value = ring_words[head_pos];
      res.rear_value  = ring_words[(head_pos + occ - 1) % DEPTH_DEFAULT];
    end
    res.is_empty  = (occ == 0);
    res.is_full   = (occ >= limit);
    res.occupancy = occ[OCC_W-1:0];
    return res;
  endfunction

  // Reports one field that differs from its prediction.
  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: result %0d field %s expected %0h, got %0h",
               $time, checked, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    bcd_out_t want;
    if (!rst_n) begin
      head_pos = 0;
      occ      = 0;
      capacity = CAP_RESET;
      owed_rd  = 0;
      owed_wr  = 0;
      errors  = 0;
      checked = 0;
      refused = 0;
      fulls   = 0;
    end else begin
      // Register reads and writes on the configuration port.
      if (psel && penable && pready && paddr == REG_CAPACITY) begin
        if (pwrite) begin
          capacity = pwdata[CAP_W-1:0];
        end else if (prdata[CAP_W-1:0] !== capacity) begin
          errors++;
          $display("%0t: capacity read expected %0h, got %0h",
                   $time, capacity, prdata[CAP_W-1:0]);
        end
      end

      // An accepted result is matched against the oldest prediction.
      if (out_valid && !out_stall) begin
        if (owed_wr == owed_rd) begin
          errors++;
          $display("%0t: result with no item outstanding, expected none, got %0h",
                   $time, out_data);
        end else begin
          want = owed_results[owed_rd % OWED_DEPTH];
          owed_rd++;
          compare_field("ok", want.ok, out_data.ok);
          compare_field("front_value", want.front_value, out_data.front_value);
          compare_field("rear_value", want.rear_value, out_data.rear_value);
          compare_field("is_empty", want.is_empty, out_data.is_empty);
          compare_field("is_full", want.is_full, out_data.is_full);
          compare_field("occupancy", want.occupancy, out_data.occupancy);
          checked++;
        end
      end

      // An accepted item moves the shadow deque on.
      if (in_valid && !in_stall) begin
        want = deque_apply(in_data);
        if (!want.ok) begin
          refused++;
        end
        if (want.is_full && !want.is_empty) begin
          fulls++;
        end
        if (owed_wr - owed_rd >= OWED_DEPTH) begin
          errors++;
          $display("%0t: results outstanding expected below %0d, got %0d",
                   $time, OWED_DEPTH, owed_wr - owed_rd);
        end
        owed_results[owed_wr % OWED_DEPTH] = want;
        owed_wr++;
      end
    end
    fail_count    <= errors;
    pending_count <= owed_wr - owed_rd;
    checked_count <= checked;
    refused_count <= refused;
    full_count    <= fulls;
  end

endmodule

>>> tb/bounded_circular_deque_unit_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// bounded_circular_deque_unit_tb: top level of the deque testbench
// Drives directed and random operations in bursts under a stalling receiver,
// steps the capacity register through its extremes between phases and gives
// the verdict from the checker's failure count.
// ============================================================================
module bounded_circular_deque_unit_tb;
  import bcd_pkg::*;

  localparam logic [VALUE_W-1:0] WORD_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic [VALUE_W-1:0] WORD_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam int PHASE_ITEMS = 102;
  localparam int PHASES      = 16;

  typedef enum int {BIAS_FILL, BIAS_DRAIN, BIAS_MIXED} op_bias_t;
  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_HOLD} stall_mode_t;

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  bcd_in_t               in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  bcd_out_t              out_data;
  logic                  psel      = 1'b0;
  logic                  penable   = 1'b0;
  logic                  pwrite    = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr     = '0;
  logic [CFG_DATA_W-1:0] pwdata    = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  int fail_count;
  int pending_count;
  int checked_count;
  int refused_count;
  int full_count;

  int          burst_left = 0;
  int          items_sent = 0;
  int          cap_settings = 0;
  stall_mode_t stall_mode = STALL_NONE;
  int          stall_left = 0;

  bounded_circular_deque_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  bounded_circular_deque_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .checked_count (checked_count),
    .refused_count (refused_count),
    .full_count    (full_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Give up long after the slowest correct run would have finished.
  initial begin
    #(3_000_000);
    $display("== FAIL ==");
    $finish;
  end

  // The receiver switches between stall patterns of random length.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_left = (stall_mode == STALL_HOLD) ? $urandom_range(1, 8) : $urandom_range(4, 40);
    end
    stall_left--;
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:     out_stall <= 1'b1;
    endcase
  end

  // Data word with extra weight on the corners.
  function automatic logic [VALUE_W-1:0] pick_word();
    case ($urandom_range(0, 15))
      0:       return WORD_MAX;
      1:       return WORD_MIN;
      2:       return '1;
      3:       return '0;
      default: return $urandom;
    endcase
  endfunction

  // Operation drawn with a bias toward filling or draining the deque, or neither.
  function automatic logic [OP_W-1:0] pick_op(op_bias_t bias);
    int roll;
    int ins_pct;
    roll = $urandom_range(0, 99);
    ins_pct = (bias == BIAS_FILL) ? 80 : (bias == BIAS_DRAIN) ? 15 : 50;
    if (roll < 3) begin
      return OP_W'(OP_PEEK + 1 + $urandom_range(0, 2));
    end else if (roll < 10) begin
      return OP_PEEK;
    end else if ($urandom_range(0, 99) < ins_pct) begin
      return $urandom_range(0, 1) ? OP_INS_FRONT : OP_INS_REAR;
    end else begin
      return $urandom_range(0, 1) ? OP_DEL_FRONT : OP_DEL_REAR;
    end
  endfunction

  // Sends one item, opening a new burst after a random gap when one ends.
  task automatic send_op(logic [OP_W-1:0] op, logic [VALUE_W-1:0] word);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        in_data  <= '{op: OP_W'($urandom), value: $urandom};
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
    end
    in_valid <= 1'b1;
    in_data  <= '{op: op, value: word};
    do @(posedge clk); while (in_stall);
    burst_left--;
    items_sent++;
  endtask

  // One configuration access: setup, access, then a return to idle.
  task automatic cfg_access(logic write, logic [CFG_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= REG_CAPACITY;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Lowers valid and waits until every result is back and the block is quiet.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Capacity changes only once the block is idle; each write is read back.
  task automatic set_capacity(int cap);
    drain();
    cfg_access(1'b1, CFG_DATA_W'(cap));
    cfg_access(1'b0, '0);
    cap_settings++;
  endtask

  initial begin
    int cap_plan [12];
    int cap;
    int seg_left;
    op_bias_t bias;

    cap_plan = '{127, 1, 64, 2, 0, 63, 100, 65, 5, 64, 3, 32};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    // Capacity should read back its reset value.
    cfg_access(1'b0, '0);

    // Empty deque: peek and refused deletes.
    send_op(OP_PEEK, pick_word());
    send_op(OP_DEL_FRONT, pick_word());
    send_op(OP_DEL_REAR, pick_word());
    // Extreme words at both ends, including one equal to the empty marker.
    send_op(OP_INS_FRONT, WORD_MAX);
    send_op(OP_INS_REAR, WORD_MIN);
    send_op(OP_INS_FRONT, '1);
    send_op(OP_INS_REAR, '0);
    // Unused op codes leave the deque alone.
    for (int c = OP_PEEK + 1; c < (1 << OP_W); c++) begin
      send_op(OP_W'(c), pick_word());
    end
    send_op(OP_DEL_REAR, pick_word());
    send_op(OP_DEL_FRONT, pick_word());
    send_op(OP_PEEK, pick_word());

    // Capacity lowered below the count: inserts refused, deletes still work.
    set_capacity(1);
    send_op(OP_INS_FRONT, pick_word());
    send_op(OP_INS_REAR, pick_word());
    send_op(OP_DEL_FRONT, pick_word());
    send_op(OP_INS_REAR, pick_word());
    send_op(OP_DEL_REAR, pick_word());

    // Zero capacity: always empty and full at once.
    set_capacity(0);
    send_op(OP_INS_FRONT, pick_word());
    send_op(OP_INS_REAR, pick_word());
    send_op(OP_PEEK, pick_word());
    send_op(OP_DEL_FRONT, pick_word());

    // Random phases, each under its own capacity, in fill, drain and mixed segments.
    for (int p = 0; p < PHASES; p++) begin
      cap = (p < 12) ? cap_plan[p] : $urandom_range(0, (1 << CAP_W) - 1);
      set_capacity(cap);
      seg_left = 0;
      bias = BIAS_MIXED;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (seg_left == 0) begin
          bias = op_bias_t'($urandom_range(0, 2));
          seg_left = $urandom_range(20, 80);
        end
        seg_left--;
        send_op(pick_op(bias), pick_word());
      end
    end

    drain();
    repeat (8) @(posedge clk);
    $display("Sent %0d items under %0d capacity settings; %0d results checked.",
             items_sent, cap_settings, checked_count);
    $display("%0d operations were refused; the deque was reported full %0d times.",
             refused_count, full_count);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> bounded_circular_deque_unit.f
rtl/bcd_pkg.sv
rtl/bounded_circular_deque_unit.sv
tb/bounded_circular_deque_checker.sv
tb/bounded_circular_deque_unit_tb.sv
